FILE: rtl/egs_pkg.sv
// ----------------------------------------------------------------------------
// egs_pkg
// Shared widths, control structs and the exp lookup table of the endpoint
// gaussian similarity block.
// ----------------------------------------------------------------------------
package egs_pkg;

  localparam int COORD_W   = 16;
  localparam int AXES      = 3;
  localparam int PT_W      = AXES * COORD_W;
  localparam int PAIRS     = 4;
  localparam int MAG_W     = COORD_W;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int PAIR_W    = SQ_W + 2;
  localparam int D_W       = PAIR_W + 1;

  localparam int KW_W      = 16;
  localparam logic [KW_W-1:0] KW_RESET = 16'd1024;
  localparam int LIM_SHIFT = 5;
  localparam int LIM_W     = 2 * KW_W + LIM_SHIFT;

  localparam int EXP_DEPTH = 64;
  localparam int IDX_W     = $clog2(EXP_DEPTH);
  localparam int TAB_IDX_W = $clog2(EXP_DEPTH + 1);
  localparam int FRAC_W    = 8;
  localparam int Q_W       = IDX_W + FRAC_W;
  localparam int RES_W     = 16;
  localparam int TERMS     = 2;
  localparam int LATENCY   = 22;
  localparam int FLIGHT_W  = $clog2(LATENCY + 1);

  typedef struct packed {
    logic valid;
    logic same;
  } dist_ctl_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } div_ctl_t;

  typedef logic [RES_W-1:0] exp_tab_t [EXP_DEPTH+1];

  // exp(-a) over a in [0,16], q2.14, built from a truncated taylor step
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t tab;
    longint unsigned x;
    longint unsigned term;
    longint unsigned e;
    longint unsigned cur;
    x    = (64'd16 << 30) / EXP_DEPTH;
    term = 64'd1 << 30;
    e    = term;
    cur  = term;
    for (int N = 1; N <= 20; N++) begin
      term = ((term * x) >> 30) / 64'(N);
      if (N % 2 == 1) begin
        e = (e >= term) ? e - term : 64'd0;
      end else begin
        e = e + term;
      end
    end
    for (int K = 0; K <= EXP_DEPTH; K++) begin
      tab[K] = RES_W'((cur + (64'd1 << 15)) >> 16);
      cur    = (cur * e + (64'd1 << 29)) >> 30;
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

FILE: rtl/egs_dist.sv
// ----------------------------------------------------------------------------
// egs_dist
// Four-stage squared endpoint distance pipeline: direct and reversed pairing.
// ----------------------------------------------------------------------------
module egs_dist (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_same,
  input  logic [egs_pkg::PT_W-1:0]  first_start,
  input  logic [egs_pkg::PT_W-1:0]  first_end,
  input  logic [egs_pkg::PT_W-1:0]  second_start,
  input  logic [egs_pkg::PT_W-1:0]  second_end,
  output egs_pkg::dist_ctl_t        out_ctl,
  output logic [egs_pkg::D_W-1:0]   d1,
  output logic [egs_pkg::D_W-1:0]   d2
);

  logic [egs_pkg::PT_W-1:0]   pt_a [egs_pkg::PAIRS];
  logic [egs_pkg::PT_W-1:0]   pt_b [egs_pkg::PAIRS];
  logic [egs_pkg::MAG_W-1:0]  mag_next [egs_pkg::PAIRS][egs_pkg::AXES];
  logic [egs_pkg::MAG_W-1:0]  mag [egs_pkg::PAIRS][egs_pkg::AXES];
  logic [egs_pkg::SQ_W-1:0]   sq [egs_pkg::PAIRS][egs_pkg::AXES];
  logic [egs_pkg::PAIR_W-1:0] psum [egs_pkg::PAIRS];
  egs_pkg::dist_ctl_t         ctl [4];

  // direct pairing first, then second tract reversed
  assign pt_a[0] = first_start;
  assign pt_b[0] = second_start;
  assign pt_a[1] = first_end;
  assign pt_b[1] = second_end;
  assign pt_a[2] = first_start;
  assign pt_b[2] = second_end;
  assign pt_a[3] = first_end;
  assign pt_b[3] = second_start;

  always_comb begin
    logic [egs_pkg::COORD_W-1:0] ca;
    logic [egs_pkg::COORD_W-1:0] cb;
    logic [egs_pkg::COORD_W:0]   diff;
    for (int p = 0; p < egs_pkg::PAIRS; p++) begin
      for (int ax = 0; ax < egs_pkg::AXES; ax++) begin
        ca   = pt_a[p][ax*egs_pkg::COORD_W +: egs_pkg::COORD_W];
        cb   = pt_b[p][ax*egs_pkg::COORD_W +: egs_pkg::COORD_W];
        diff = {ca[egs_pkg::COORD_W-1], ca} - {cb[egs_pkg::COORD_W-1], cb};
        if (diff[egs_pkg::COORD_W]) begin
          mag_next[p][ax] = egs_pkg::MAG_W'(-diff);
        end else begin
          mag_next[p][ax] = egs_pkg::MAG_W'(diff);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        ctl[k] <= '0;
      end
    end else begin
      ctl[0] <= '{valid: in_valid, same: in_same};
      for (int k = 1; k < 4; k++) begin
        ctl[k] <= ctl[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < egs_pkg::PAIRS; p++) begin
      for (int ax = 0; ax < egs_pkg::AXES; ax++) begin
        mag[p][ax] <= mag_next[p][ax];
        sq[p][ax]  <= egs_pkg::SQ_W'(mag[p][ax]) * egs_pkg::SQ_W'(mag[p][ax]);
      end
      psum[p] <= egs_pkg::PAIR_W'(sq[p][0]) + egs_pkg::PAIR_W'(sq[p][1])
               + egs_pkg::PAIR_W'(sq[p][2]);
    end
    d1 <= egs_pkg::D_W'(psum[0]) + egs_pkg::D_W'(psum[1]);
    d2 <= egs_pkg::D_W'(psum[2]) + egs_pkg::D_W'(psum[3]);
  end

  assign out_ctl = ctl[3];

endmodule

FILE: rtl/egs_div.sv
// ----------------------------------------------------------------------------
// egs_div
// Pipelined restoring divider, one quotient bit per stage: gives
// floor(num * 2^Q_W / lim) for num below lim.
// ----------------------------------------------------------------------------
module egs_div (
  input  logic                       clk,
  input  logic                       rst,
  input  egs_pkg::div_ctl_t          in_ctl,
  input  logic [egs_pkg::D_W-1:0]    num,
  input  logic [egs_pkg::LIM_W-1:0]  lim,
  output egs_pkg::div_ctl_t          out_ctl,
  output logic [egs_pkg::Q_W-1:0]    quo
);

  logic [egs_pkg::LIM_W-1:0] rem [egs_pkg::Q_W];
  logic [egs_pkg::Q_W-1:0]   q   [egs_pkg::Q_W];
  egs_pkg::div_ctl_t         ctl [egs_pkg::Q_W];

  for (genvar k = 0; k < egs_pkg::Q_W; k++) begin : g_step
    logic [egs_pkg::LIM_W-1:0] rin;
    logic [egs_pkg::Q_W-1:0]   qin;
    egs_pkg::div_ctl_t         cin;
    logic [egs_pkg::LIM_W:0]   dbl;
    logic                      ge;

    if (k == 0) begin : g_first
      assign rin = egs_pkg::LIM_W'(num);
      assign qin = '0;
      assign cin = in_ctl;
    end else begin : g_rest
      assign rin = rem[k-1];
      assign qin = q[k-1];
      assign cin = ctl[k-1];
    end

    assign dbl = {rin, 1'b0};
    assign ge  = dbl >= {1'b0, lim};

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k] <= '0;
      end else begin
        ctl[k] <= cin;
      end
      rem[k] <= ge ? egs_pkg::LIM_W'(dbl - {1'b0, lim}) : egs_pkg::LIM_W'(dbl);
      q[k]   <= {qin[egs_pkg::Q_W-2:0], ge};
    end
  end

  assign out_ctl = ctl[egs_pkg::Q_W-1];
  assign quo     = q[egs_pkg::Q_W-1];

endmodule

FILE: rtl/endpoint_gaussian_similarity.sv
// ----------------------------------------------------------------------------
// endpoint_gaussian_similarity
// Orientation-invariant gaussian similarity of two tracts from their endpoints.
// ----------------------------------------------------------------------------
// Takes one pair of tracts per clock while busy is low and returns the result
// on similarity with done high for one cycle; results leave in order and
// cannot be held off. The pipeline is made of four distance stages, one
// compare stage, the 14-stage restoring divider (one quotient bit per stage)
// and three table, interpolation and sum stages. busy is high during reset
// and for one cycle after each kernel_width transaction while the variance
// limit is recomputed. cfg_ready is low while start is high or any pair is
// still in flight.
module endpoint_gaussian_similarity (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       same_tract,
  input  logic [egs_pkg::PT_W-1:0]   first_start,
  input  logic [egs_pkg::PT_W-1:0]   first_end,
  input  logic [egs_pkg::PT_W-1:0]   second_start,
  input  logic [egs_pkg::PT_W-1:0]   second_end,
  output logic [egs_pkg::RES_W-1:0]  similarity,
  output logic                       done,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [egs_pkg::KW_W-1:0]   cfg_data
);

  logic [egs_pkg::KW_W-1:0]    kernel_width;
  logic [egs_pkg::KW_W-1:0]    kw_eff;
  logic [2*egs_pkg::KW_W-1:0]  kw_sq;
  logic [egs_pkg::LIM_W-1:0]   lim;
  logic                        accept;
  logic [egs_pkg::FLIGHT_W-1:0] in_flight;

  egs_pkg::dist_ctl_t          dist_ctl;
  logic [egs_pkg::D_W-1:0]     dist_d [egs_pkg::TERMS];
  egs_pkg::div_ctl_t           cmp_ctl [egs_pkg::TERMS];
  logic [egs_pkg::D_W-1:0]     cmp_d [egs_pkg::TERMS];
  egs_pkg::div_ctl_t           div_ctl [egs_pkg::TERMS];
  logic [egs_pkg::Q_W-1:0]     div_q [egs_pkg::TERMS];

  logic [egs_pkg::RES_W-1:0]   hi [egs_pkg::TERMS];
  logic [egs_pkg::RES_W-1:0]   dif [egs_pkg::TERMS];
  logic [egs_pkg::FRAC_W-1:0]  frac [egs_pkg::TERMS];
  logic                        tab_zero [egs_pkg::TERMS];
  logic [egs_pkg::RES_W-1:0]   term [egs_pkg::TERMS];
  logic                        tab_valid;
  logic                        int_valid;

  assign accept    = start & ~busy;
  assign cfg_ready = ~busy & ~start & (in_flight == '0);

  // pairs accepted and not yet returned
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + egs_pkg::FLIGHT_W'(accept) - egs_pkg::FLIGHT_W'(done);
    end
  end

  // register write and variance limit 32 * s^2
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_width <= egs_pkg::KW_RESET;
      busy         <= 1'b1;
    end else begin
      busy <= cfg_valid & cfg_ready;
      if (cfg_valid && cfg_ready) begin
        kernel_width <= cfg_data;
      end
    end
  end

  assign kw_eff = (kernel_width == '0) ? egs_pkg::KW_W'(1) : kernel_width;
  assign kw_sq  = (2*egs_pkg::KW_W)'(kw_eff) * (2*egs_pkg::KW_W)'(kw_eff);

  always_ff @(posedge clk) begin
    lim <= {kw_sq, {egs_pkg::LIM_SHIFT{1'b0}}};
  end

  egs_dist u_dist (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (accept),
    .in_same      (same_tract),
    .first_start  (first_start),
    .first_end    (first_end),
    .second_start (second_start),
    .second_end   (second_end),
    .out_ctl      (dist_ctl),
    .d1           (dist_d[0]),
    .d2           (dist_d[1])
  );

  for (genvar j = 0; j < egs_pkg::TERMS; j++) begin : g_term
    logic [egs_pkg::IDX_W-1:0]            idx;
    logic [egs_pkg::RES_W-1:0]            tab_hi;
    logic [egs_pkg::RES_W-1:0]            tab_lo;
    logic [egs_pkg::RES_W+egs_pkg::FRAC_W-1:0] prod;

    // out of range or same tract gives a zero term
    always_ff @(posedge clk) begin
      if (rst) begin
        cmp_ctl[j] <= '0;
      end else begin
        cmp_ctl[j] <= '{valid: dist_ctl.valid,
                        zero:  dist_ctl.same
                               || (egs_pkg::LIM_W'(dist_d[j]) >= lim)};
      end
      cmp_d[j] <= dist_d[j];
    end

    egs_div u_div (
      .clk     (clk),
      .rst     (rst),
      .in_ctl  (cmp_ctl[j]),
      .num     (cmp_d[j]),
      .lim     (lim),
      .out_ctl (div_ctl[j]),
      .quo     (div_q[j])
    );

    assign idx    = div_q[j][egs_pkg::Q_W-1:egs_pkg::FRAC_W];
    assign tab_hi = egs_pkg::EXP_TAB[egs_pkg::TAB_IDX_W'(idx)];
    assign tab_lo = egs_pkg::EXP_TAB[egs_pkg::TAB_IDX_W'(idx)
                                     + egs_pkg::TAB_IDX_W'(1)];
    assign prod   = (egs_pkg::RES_W+egs_pkg::FRAC_W)'(dif[j])
                  * (egs_pkg::RES_W+egs_pkg::FRAC_W)'(frac[j]);

    // linear interpolation between neighbouring table entries
    always_ff @(posedge clk) begin
      hi[j]       <= tab_hi;
      dif[j]      <= tab_hi - tab_lo;
      frac[j]     <= div_q[j][egs_pkg::FRAC_W-1:0];
      tab_zero[j] <= div_ctl[j].zero;
      term[j]     <= tab_zero[j] ? '0
                   : hi[j] - egs_pkg::RES_W'(prod >> egs_pkg::FRAC_W);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_valid <= 1'b0;
      int_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      tab_valid <= div_ctl[0].valid;
      int_valid <= tab_valid;
      done      <= int_valid;
    end
    similarity <= term[0] + term[1];
  end

  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, egs_pkg::LATENCY))
    else $error("result without a matching input transaction");

  assert property (@(posedge clk) disable iff (rst)
    done && $past(start && !busy && same_tract, egs_pkg::LATENCY)
    |-> similarity == '0)
    else $error("same tract gave a non-zero similarity");

  assert property (@(posedge clk) disable iff (rst)
    done |-> similarity <= egs_pkg::RES_W'(32768))
    else $error("similarity above 2.0");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the endpoint gaussian similarity block against a predictor of its
// own. Directed pairs cover the same-tract flag, coincident and extreme
// points and the zero and full-scale kernel widths. Random pairs then run
// under several kernel widths with bursty input. Each result is compared
// with the oldest prediction in a queue.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  PIPE_DEPTH  = 22;
  localparam int  LUT_DEPTH   = 64;
  localparam int  CYCLE_LIMIT = 300000;
  localparam int  PT_BITS     = egs_pkg::PT_W;

  typedef logic [PT_BITS-1:0] point_t;

  typedef struct {
    logic   same;
    point_t fs;
    point_t fe;
    point_t ss;
    point_t se;
  } tract_pair_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      same_tract = 1'b0;
  point_t                    first_start = '0;
  point_t                    first_end = '0;
  point_t                    second_start = '0;
  point_t                    second_end = '0;
  logic [egs_pkg::RES_W-1:0] similarity;
  logic                      done;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [egs_pkg::KW_W-1:0]  cfg_data = '0;

  logic [15:0] exp_lut [LUT_DEPTH+1];
  logic [15:0] sigma_now = 16'd1024;
  logic [15:0] expected_sims [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          burst_left = 0;

  endpoint_gaussian_similarity u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .same_tract   (same_tract),
    .first_start  (first_start),
    .first_end    (first_end),
    .second_start (second_start),
    .second_end   (second_end),
    .similarity   (similarity),
    .done         (done),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL endpoint_gaussian_similarity");
      $finish;
    end
  end

  // exp(-a) samples over a in [0,16], q2.14, from a truncated taylor step
  task automatic lut_fill();
    longint unsigned x;
    longint unsigned term;
    longint unsigned step;
    longint unsigned cur;
    x    = (64'd16 << 30) / LUT_DEPTH;
    term = 64'd1 << 30;
    step = term;
    cur  = term;
    for (int n = 1; n <= 20; n++) begin
      term = ((term * x) >> 30) / longint'(n);
      if (n % 2 == 1) begin
        step = (step >= term) ? step - term : 64'd0;
      end else begin
        step = step + term;
      end
    end
    for (int k = 0; k <= LUT_DEPTH; k++) begin
      exp_lut[k] = 16'((cur + (64'd1 << 15)) >> 16);
      cur        = (cur * step + (64'd1 << 29)) >> 30;
    end
  endtask

  function automatic longint unsigned squared_gap(point_t a, point_t b);
    logic signed [15:0] ca;
    logic signed [15:0] cb;
    longint             diff;
    longint unsigned    sum;
    sum = 0;
    for (int ax = 0; ax < 3; ax++) begin
      ca   = a[ax*16 +: 16];
      cb   = b[ax*16 +: 16];
      diff = longint'(ca) - longint'(cb);
      sum += longint'(diff * diff);
    end
    return sum;
  endfunction

  function automatic longint unsigned kernel_term(longint unsigned d, longint unsigned lim);
    longint unsigned p;
    longint unsigned idx;
    longint unsigned frac;
    longint unsigned hi;
    longint unsigned lo;
    if (d >= lim) return 0;
    p    = (d * LUT_DEPTH * 256) / lim;
    idx  = p >> 8;
    frac = p & 255;
    if (idx >= LUT_DEPTH) return 0;
    hi = exp_lut[idx];
    lo = exp_lut[idx + 1];
    return hi - (((hi - lo) * frac) >> 8);
  endfunction

  function automatic logic [15:0] predict_similarity(tract_pair_t t);
    longint unsigned s;
    longint unsigned lim;
    longint unsigned d1;
    longint unsigned d2;
    if (t.same) return 16'd0;
    s   = (sigma_now == 16'd0) ? 64'd1 : longint'(sigma_now);
    lim = 32 * s * s;
    d1  = squared_gap(t.fs, t.ss) + squared_gap(t.fe, t.se);
    d2  = squared_gap(t.fs, t.se) + squared_gap(t.fe, t.ss);
    return 16'(kernel_term(d1, lim) + kernel_term(d2, lim));
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_sims.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, similarity);
        mismatches++;
      end else begin
        if (similarity !== expected_sims[0]) begin
          $display("%0t: similarity mismatch, expected %0d, actual %0d",
                   $time, expected_sims[0], similarity);
          mismatches++;
        end
        void'(expected_sims.pop_front());
      end
    end
  end

  function automatic point_t pt(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return {z, y, x};
  endfunction

  function automatic point_t random_point();
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  function automatic point_t near_point(point_t centre, int spread);
    point_t p;
    int     off;
    for (int ax = 0; ax < 3; ax++) begin
      off = int'($urandom_range(0, 2 * spread)) - spread;
      p[ax*16 +: 16] = centre[ax*16 +: 16] + 16'(off);
    end
    return p;
  endfunction

  // bursts of random length, random gaps between them
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20);
    end
    burst_left--;
  endtask

  task automatic send_pair(tract_pair_t t);
    pace();
    start        <= 1'b1;
    same_tract   <= t.same;
    first_start  <= t.fs;
    first_end    <= t.fe;
    second_start <= t.ss;
    second_end   <= t.se;
    do @(posedge clk); while (busy);
    expected_sims.push_back(predict_similarity(t));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_sims.size() != 0) @(posedge clk);
  endtask

  task automatic set_kernel_width(logic [15:0] w);
    wait_drained();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sigma_now = w;
  endtask

  task automatic send_points(logic same, point_t fs, point_t fe, point_t ss, point_t se);
    tract_pair_t t;
    t.same = same;
    t.fs   = fs;
    t.fe   = fe;
    t.ss   = ss;
    t.se   = se;
    send_pair(t);
  endtask

  task automatic test_same_tract();
    send_points(1'b1, '0, '0, '0, '0);
    send_points(1'b1, pt(16'h7fff, 16'h7fff, 16'h7fff), pt(16'h8000, 16'h8000, 16'h8000),
                '1, pt(16'h8000, 16'h7fff, 16'h0000));
    send_points(1'b1, random_point(), random_point(), random_point(), random_point());
  endtask

  task automatic test_coincident_points();
    point_t hi;
    point_t lo;
    hi = pt(16'h7fff, 16'h7fff, 16'h7fff);
    lo = pt(16'h8000, 16'h8000, 16'h8000);
    send_points(1'b0, '0, '0, '0, '0);
    send_points(1'b0, hi, hi, hi, hi);
    send_points(1'b0, lo, lo, lo, lo);
  endtask

  task automatic test_coord_extremes();
    point_t hi;
    point_t lo;
    hi = pt(16'h7fff, 16'h7fff, 16'h7fff);
    lo = pt(16'h8000, 16'h8000, 16'h8000);
    // matched ends meet, reversed ends far apart
    send_points(1'b0, hi, lo, hi, lo);
    // second tract reversed
    send_points(1'b0, hi, lo, lo, hi);
    // every pair at the largest distance
    send_points(1'b0, hi, hi, lo, lo);
    send_points(1'b0, pt(16'haaaa, 16'h5555, 16'haaaa), pt(16'h5555, 16'haaaa, 16'h5555),
                pt(16'h5555, 16'h5555, 16'haaaa), pt(16'haaaa, 16'haaaa, 16'h5555));
  endtask

  task automatic test_kernel_width_zero();
    set_kernel_width(16'd0);
    // distance sum exactly at the cut-off
    send_points(1'b0, '0, '0, pt(16'd4, 16'd0, 16'd0), pt(16'd4, 16'd0, 16'd0));
    send_points(1'b0, '0, '0, pt(16'd3, 16'd0, 16'd0), pt(16'd4, 16'd0, 16'd0));
    send_points(1'b0, '0, '0, '0, pt(16'd0, 16'd0, 16'hffff));
    set_kernel_width(16'd1);
    send_points(1'b0, '0, '0, pt(16'd4, 16'd0, 16'd0), pt(16'd4, 16'd0, 16'd0));
    send_points(1'b0, '0, pt(16'd1, 16'd1, 16'd1), pt(16'd2, 16'd2, 16'd2), '0);
  endtask

  task automatic test_kernel_width_max();
    set_kernel_width(16'hffff);
    send_points(1'b0, pt(16'h7fff, 16'h7fff, 16'h7fff), pt(16'h7fff, 16'h7fff, 16'h7fff),
                pt(16'h8000, 16'h8000, 16'h8000), pt(16'h8000, 16'h8000, 16'h8000));
    send_points(1'b0, random_point(), random_point(), random_point(), random_point());
  endtask

  task automatic random_pairs(int count, bit hold_midway);
    tract_pair_t t;
    int          sel;
    int          spread;
    longint      s_eff;
    bit          swap;
    for (int n = 0; n < count; n++) begin
      if (hold_midway && n == count / 2) wait_drained();
      sel    = $urandom_range(0, 99);
      s_eff  = (sigma_now == 16'd0) ? 1 : longint'(sigma_now);
      spread = int'((s_eff * $urandom_range(1, 12)) / 4);
      if (spread > 32767) spread = 32767;
      t.same = (sel < 6);
      if (sel < 18) begin
        t.fs = random_point();
        t.fe = random_point();
        t.ss = random_point();
        t.se = random_point();
      end else begin
        swap = $urandom_range(0, 1);
        t.fs = random_point();
        t.fe = ($urandom_range(0, 3) == 0) ? random_point()
                                           : near_point(t.fs, $urandom_range(0, 32767));
        t.ss = near_point(swap ? t.fe : t.fs, spread);
        t.se = near_point(swap ? t.fs : t.fe, spread);
      end
      send_pair(t);
    end
  endtask

  task automatic test_random_widths();
    set_kernel_width(16'd1024);
    random_pairs(135, 1'b1);
    set_kernel_width(16'd0);
    random_pairs(135, 1'b0);
    set_kernel_width(16'hffff);
    random_pairs(135, 1'b0);
    set_kernel_width(16'($urandom_range(2, 64)));
    random_pairs(135, 1'b0);
    set_kernel_width(16'($urandom_range(65, 4095)));
    random_pairs(135, 1'b1);
    set_kernel_width(16'($urandom_range(1, 65535)));
    random_pairs(135, 1'b0);
    set_kernel_width(16'd1);
    random_pairs(135, 1'b0);
  endtask

  initial begin
    lut_fill();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_same_tract();
    test_coincident_points();
    test_coord_extremes();
    test_kernel_width_zero();
    test_kernel_width_max();
    test_random_widths();
    wait_drained();
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS endpoint_gaussian_similarity");
    end else begin
      $display("FAIL endpoint_gaussian_similarity");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/egs_pkg.sv
rtl/egs_dist.sv
rtl/egs_div.sv
rtl/endpoint_gaussian_similarity.sv
tb/testbench.sv
